// ===== sv/itf_pkg.sv =====
// Package: shared constants, command/status types and helpers for the integer text formatter.
`timescale 1ns / 1ps
package itf_pkg;
   localparam int VALUE_BITS_DEFAULT = 64;
   localparam int MAX_FIELD_DEFAULT  = 64;
   localparam int DIGIT_DEPTH        = 64;
   localparam int DIGIT_IDX_BITS     = 6;
   localparam int CNT_BITS           = 7;

   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_HEX = 2'd1;
   localparam logic [1:0] BASE_BIN = 2'd2;
   localparam logic [1:0] BASE_OCT = 2'd3;

   localparam int FMT_LEFT  = 0;
   localparam int FMT_PLUS  = 1;
   localparam int FMT_BLANK = 2;
   localparam int FMT_ALT   = 3;
   localparam int FMT_ZPAD  = 4;
   localparam int FMT_CAPS  = 5;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_PLUS  = 7'h2b;
   localparam logic [6:0] CH_MINUS = 7'h2d;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture the request
      logic div_step;   // one digit extraction step
      logic layout;     // compute sign, prefix, padding
      logic fetch;      // read the digits for the next pair
      logic emit;       // produce one output pair
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic div_done;
      logic emit_last;
   } sts_type;

   function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
      logic [6:0] c;
      if (d < 4'd10) c = CH_ZERO + {3'd0, d};
      else if (upper) c = 7'h41 + {3'd0, d} - 7'd10;
      else c = 7'h61 + {3'd0, d} - 7'd10;
      return c;
   endfunction
endpackage

// ===== sv/itf_ctrl.sv =====
// Controller state machine for the integer text formatter.
`timescale 1ns / 1ps
module itf_ctrl import itf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_fire,
   input  logic    rsp_space,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_ready
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_LAYOUT = 3'd2;
   localparam logic [2:0] ST_FETCH  = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_LAYOUT;
            else cmd.div_step = 1'b1;
         end
         ST_LAYOUT: begin
            cmd.layout = 1'b1;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_space) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) state_in = ST_IDLE;
               else state_in = ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ===== sv/itf_datapath.sv =====
// Datapath: digit extraction, digit store, layout and character pair emission.
`timescale 1ns / 1ps
module itf_datapath import itf_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_FIELD  = MAX_FIELD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [63:0]           magnitude,
   input  logic                  signed_conv,
   input  logic                  negative,
   input  logic [1:0]            base_code,
   input  logic [5:0]            format_flags,
   input  logic [6:0]            field_width,
   input  logic signed [7:0]     precision,
   output logic [6:0]            out_first,
   output logic [6:0]            out_second,
   output logic                  out_second_valid,
   output logic                  out_last,
   output logic [6:0]            out_total
);
   localparam logic [6:0] MAX_F = 7'(MAX_FIELD);

   logic [VALUE_BITS-1:0] rem_ff;
   logic [6:0] dcnt_ff;
   logic [6:0] pos_ff;
   logic [1:0] base_ff;
   logic [5:0] flags_ff;
   logic       sconv_ff, neg_ff;
   logic [6:0] width_ff, prec_ff;
   logic       precision_none_ff;
   logic       started_ff;
   logic [3:0] dig_mem [DIGIT_DEPTH];
   logic [3:0] lead_ff;
   logic [3:0] dig0_ff, dig1_ff;

   // layout results
   logic [6:0] pad_ff, zeros_ff, total_ff;
   logic [6:0] sign_ch_ff;
   logic       has_sign_ff;
   logic [1:0] pfx_len_ff;
   logic [6:0] pfx1_ff;

   // decimal step: quotient by ten via shift-add reciprocal, built up over the dphase phases
   logic [VALUE_BITS-1:0] qacc_ff, qacc_in;
   logic [1:0]            dphase_ff;
   logic [VALUE_BITS-1:0] dec_a;
   logic [4:0]            dec_prod, dec_rem;
   always_comb begin
      dec_a   = '0;
      qacc_in = qacc_ff;
      case (dphase_ff)
         2'd0: begin
            dec_a   = (rem_ff >> 1) + (rem_ff >> 2);
            qacc_in = dec_a + (dec_a >> 4);
         end
         2'd1: begin
            dec_a   = qacc_ff + (qacc_ff >> 8);
            qacc_in = dec_a + (dec_a >> 16);
         end
         2'd2: begin
            dec_a   = qacc_ff + (qacc_ff >> 32);
            qacc_in = dec_a >> 3;
         end
         default: qacc_in = qacc_ff;
      endcase
   end
   // estimate is at most one low, so the remainder is below 20: five bits suffice
   assign dec_prod = {qacc_ff[1:0], 3'd0} + {qacc_ff[3:0], 1'b0};
   assign dec_rem  = rem_ff[4:0] - dec_prod;

   // quotient and remainder by base (shift for powers of two)
   logic [VALUE_BITS-1:0] quot;
   logic [3:0]            rdig;
   always_comb begin
      case (base_ff)
         BASE_HEX: begin quot = rem_ff >> 4; rdig = rem_ff[3:0]; end
         BASE_BIN: begin quot = rem_ff >> 1; rdig = {3'd0, rem_ff[0]}; end
         BASE_OCT: begin quot = rem_ff >> 3; rdig = {1'b0, rem_ff[2:0]}; end
         default: begin
            if (dec_rem > 5'd9) begin
               quot = qacc_ff + {{(VALUE_BITS-1){1'b0}}, 1'b1};
               rdig = 4'(dec_rem - 5'd10);
            end else begin
               quot = qacc_ff;
               rdig = dec_rem[3:0];
            end
         end
      endcase
   end

   logic div_fin;
   logic fin;
   assign div_fin = started_ff && (rem_ff == '0 || dcnt_ff == 7'(DIGIT_DEPTH));
   assign sts = '{div_done: div_fin, emit_last: fin};

   // zero-value case: one digit unless precision is exactly 0
   logic no_zero_digit;
   assign no_zero_digit = (prec_ff == 7'd0) && !precision_none_ff;

   logic step_zero, step_digit, dig_we;
   logic [3:0] dig_wdata;
   assign step_zero  = cmd.div_step && !started_ff && rem_ff == '0;
   assign step_digit = cmd.div_step && !step_zero &&
                       (base_ff != BASE_DEC || dphase_ff == 2'd3);
   assign dig_we     = step_digit || (step_zero && !no_zero_digit);
   assign dig_wdata  = step_zero ? 4'd0 : rdig;

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         dcnt_ff    <= '0;
         rem_ff     <= '0;
         dphase_ff  <= '0;
      end else if (cmd.load) begin
         rem_ff     <= magnitude[VALUE_BITS-1:0];
         dcnt_ff    <= '0;
         started_ff <= 1'b0;
         dphase_ff  <= '0;
      end else if (cmd.div_step) begin
         started_ff <= 1'b1;
         if (step_zero) begin
            if (!no_zero_digit) dcnt_ff <= 7'd1;
         end else if (step_digit) begin
            dcnt_ff   <= dcnt_ff + 7'd1;
            rem_ff    <= quot;
            dphase_ff <= '0;
         end else begin
            dphase_ff <= dphase_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_step && base_ff == BASE_DEC) qacc_ff <= qacc_in;
   end

   always_ff @(posedge clock) begin
      if (dig_we) dig_mem[dcnt_ff[DIGIT_IDX_BITS-1:0]] <= dig_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff  <= base_code;
         flags_ff <= format_flags;
         sconv_ff <= signed_conv;
         neg_ff   <= negative;
         width_ff <= (field_width > MAX_F) ? MAX_F : field_width;
         precision_none_ff <= precision[7];
         prec_ff  <= precision[7] ? 7'd0 :
                     ((precision[6:0] > MAX_F) ? MAX_F : precision[6:0]);
      end
   end

   // digit positions for the current pair: dcnt-1-(p-b4)
   logic [6:0] base4;
   assign base4 = ((!flags_ff[FMT_LEFT] && !flags_ff[FMT_ZPAD]) ? pad_ff : 7'd0)
                + {6'd0, has_sign_ff} + {5'd0, pfx_len_ff}
                + ((!flags_ff[FMT_LEFT] && flags_ff[FMT_ZPAD]) ? pad_ff : 7'd0)
                + zeros_ff;
   logic [6:0] pos1;
   logic [5:0] di0, di1;
   assign pos1 = pos_ff + 7'd1;
   assign di0 = 6'(dcnt_ff - 7'd1 - (pos_ff - base4));
   assign di1 = 6'(dcnt_ff - 7'd1 - (pos1 - base4));

   // digit store read port: the pair's two digits on fetch, else the leading digit
   logic [5:0] lead_idx;
   assign lead_idx = 6'(dcnt_ff - 7'd1);
   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         dig0_ff <= dig_mem[di0];
         dig1_ff <= dig_mem[di1];
      end else begin
         lead_ff <= dig_mem[lead_idx];
      end
   end

   // layout computed combinationally, registered on cmd.layout
   logic       sgn_on;
   logic [6:0] sgn_ch;
   logic [1:0] plen;
   logic [6:0] p1;
   logic [6:0] zer, tl, pd;
   always_comb begin
      sgn_on = 1'b0;
      sgn_ch = CH_SPACE;
      if (sconv_ff && base_ff == BASE_DEC) begin
         if (neg_ff) begin sgn_on = 1'b1; sgn_ch = CH_MINUS; end
         else if (flags_ff[FMT_PLUS]) begin sgn_on = 1'b1; sgn_ch = CH_PLUS; end
         else if (flags_ff[FMT_BLANK]) begin sgn_on = 1'b1; sgn_ch = CH_SPACE; end
      end
      plen = 2'd0;
      p1   = 7'h78;
      if (flags_ff[FMT_ALT]) begin
         if (base_ff == BASE_HEX && dcnt_ff != 0) begin
            plen = 2'd2; p1 = flags_ff[FMT_CAPS] ? 7'h58 : 7'h78;
         end else if (base_ff == BASE_BIN && dcnt_ff != 0) begin
            plen = 2'd2; p1 = 7'h62;
         end else if (base_ff == BASE_OCT && (dcnt_ff == 0 || lead_ff != 4'd0)) begin
            plen = 2'd1;
         end
      end
      zer = (prec_ff > dcnt_ff) ? prec_ff - dcnt_ff : 7'd0;
      tl  = {5'd0, plen} + {6'd0, sgn_on} + zer + dcnt_ff;
      pd  = (width_ff > tl) ? width_ff - tl : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (cmd.layout) begin
         has_sign_ff <= sgn_on;
         sign_ch_ff  <= sgn_ch;
         pfx_len_ff  <= plen;
         pfx1_ff     <= p1;
         zeros_ff    <= zer;
         pad_ff      <= pd;
         total_ff    <= tl + pd;
      end
   end

   // character at a text position, by segment
   function automatic logic [6:0] char_at(input logic [6:0] p, input logic [3:0] dv);
      logic [6:0] c, b0, b1, b2, b3, b4, b5;
      logic       lf, zf;
      lf = flags_ff[FMT_LEFT];
      zf = flags_ff[FMT_ZPAD];
      b0 = (!lf && !zf) ? pad_ff : 7'd0;
      b1 = b0 + {6'd0, has_sign_ff};
      b2 = b1 + {5'd0, pfx_len_ff};
      b3 = b2 + ((!lf && zf) ? pad_ff : 7'd0);
      b4 = b3 + zeros_ff;
      b5 = b4 + dcnt_ff;
      if (p < b0) c = CH_SPACE;
      else if (p < b1) c = sign_ch_ff;
      else if (p < b2) c = (p == b1) ? CH_ZERO : pfx1_ff;
      else if (p < b4) c = CH_ZERO;
      else if (p < b5) c = digit_char(dv, flags_ff[FMT_CAPS]);
      else c = CH_SPACE;
      return c;
   endfunction

   logic [6:0] c0, c1;
   logic       has2;
   assign c0   = (pos_ff < total_ff) ? char_at(pos_ff, dig0_ff) : 7'd0;
   assign has2 = pos1 < total_ff;
   assign c1   = has2 ? char_at(pos1, dig1_ff) : 7'd0;
   assign fin  = (pos_ff + 7'd2) >= total_ff;

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else if (cmd.layout) pos_ff <= '0;
      else if (cmd.emit) pos_ff <= pos_ff + 7'd2;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_first        <= c0;
         out_second       <= c1;
         out_second_valid <= has2;
         out_last         <= fin;
         out_total        <= fin ? total_ff : 7'd0;
      end
   end
endmodule

// ===== sv/integer_text_formatter.sv =====
// Top level: printf-style integer formatter, stream in, character pairs out.
//
//  channel | direction | payload
//  req_    | in        | tdata: magnitude, signed_conv, negative, base_code, format_flags,
//          |           |        field_width, precision
//  rsp_    | out       | tdata: char_first, char_second, second_valid, written_total; tlast
//
// One item: the accept, then digit extraction (a shift for hex, binary and octal, a
// shift-add divide by ten for decimal) and a closing step, up to 64 binary or 20
// decimal digits; then the layout; then, for each pair of characters, a digit store
// fetch and the transfer (up to 33 pairs). One item is handled at a time.
// Reset is synchronous and active high; it clears the controller and output valid.
// A stalled rsp_ side holds the current pair and delays the rest of the item.
`timescale 1ns / 1ps
module integer_text_formatter import itf_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
   parameter int MAX_FIELD  = MAX_FIELD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [63:0] magnitude, [64] signed_conv, [65] negative, [67:66] base_code,
   // [73:68] format_flags, [80:74] field_width, [88:81] precision
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] char_first, [13:7] char_second, [14] second_valid, [21:15] written_total
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);
   cmd_type cmd;
   sts_type sts;
   logic    req_fire, rsp_space;
   logic    rsp_valid_ff;
   logic [6:0] c_first, c_second, c_total;
   logic       c_sv, c_last;

   assign req_fire  = req_tvalid && req_tready;
   // output register is free or being drained this cycle
   assign rsp_space = !rsp_valid_ff || rsp_tready;

   itf_ctrl u_ctrl (
      .clock, .reset, .req_fire, .rsp_space, .sts, .cmd, .req_ready(req_tready)
   );

   itf_datapath #(.VALUE_BITS(VALUE_BITS), .MAX_FIELD(MAX_FIELD)) u_dp (
      .clock, .reset, .cmd, .sts,
      .magnitude(req_tdata[63:0]),
      .signed_conv(req_tdata[64]),
      .negative(req_tdata[65]),
      .base_code(req_tdata[67:66]),
      .format_flags(req_tdata[73:68]),
      .field_width(req_tdata[80:74]),
      .precision(req_tdata[88:81]),
      .out_first(c_first), .out_second(c_second), .out_second_valid(c_sv),
      .out_last(c_last), .out_total(c_total)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, c_total, c_sv, c_second, c_first};
   assign rsp_tlast  = c_last;

   // a new request is never taken while a result is still being built
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !req_tready) else $error("request ready during emission");
   // a transfer of the last pair returns the block to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.emit_last) |=> req_tready) else $error("not idle after last");
   // second character is zero when absent
   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[14]) |-> rsp_tdata[13:7] == 7'd0)
      else $error("stray second character");
endmodule
